[src/byte_stuffing_deframer_defines.svh]
// Assertion macros for the byte stuffing deframer.
`ifndef BYTE_STUFFING_DEFRAMER_DEFINES_SVH
`define BYTE_STUFFING_DEFRAMER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BSD_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
`define BSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BSD_ASSERT(lbl, cond)
`define BSD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/bsd_pkg.sv]
// Shared types and constants of the byte stuffing deframer.
package bsd_pkg;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END = 1'd1;
	localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'h00;
	localparam logic [BYTE_W-1:0] END_RST = 8'h01;
	localparam int TOKQ_DEPTH = 4;
	localparam int TOKQ_AW = $clog2(TOKQ_DEPTH);
	localparam int TOKQ_CW = $clog2(TOKQ_DEPTH + 1);

	// one classified link byte: data byte or frame end
	typedef struct packed {
		logic is_end;
		logic [BYTE_W-1:0] data;
	} token_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;
endpackage

[src/bsd_front.sv]
// Front end: accepts link bytes and strips escapes into tokens.
module bsd_front (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [bsd_pkg::BYTE_W-1:0] rx_byte,
	input  logic [bsd_pkg::BYTE_W-1:0] escape_byte,
	input  logic [bsd_pkg::BYTE_W-1:0] end_byte,
	input  bsd_pkg::qstat_t tq_stat,
	output logic full,
	output logic tok_push,
	output bsd_pkg::token_t tok
);
	import bsd_pkg::*;

	logic esc_pending_q;
	logic acc;

	assign full = tq_stat.full;
	assign acc = push && !full;

	always_comb begin
		tok.is_end = esc_pending_q && (rx_byte == end_byte);
		tok.data = rx_byte;
		// a bare escape produces no token
		tok_push = acc && (esc_pending_q || (rx_byte != escape_byte));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_pending_q <= 1'b0;
		end else if (acc) begin
			esc_pending_q <= !esc_pending_q && (rx_byte == escape_byte);
		end
	end
endmodule

[src/bsd_tokq.sv]
// Token queue between front and back end.
`include "byte_stuffing_deframer_defines.svh"
module bsd_tokq (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  bsd_pkg::token_t wr_tok,
	input  logic pop,
	output bsd_pkg::token_t rd_tok,
	output bsd_pkg::qstat_t stat
);
	import bsd_pkg::*;

	token_t mem_q [TOKQ_DEPTH];
	logic [TOKQ_AW-1:0] wr_ptr_q;
	logic [TOKQ_AW-1:0] rd_ptr_q;
	logic [TOKQ_CW-1:0] cnt_q;

	assign stat.empty = (cnt_q == '0);
	assign stat.full = (cnt_q == TOKQ_CW'(TOKQ_DEPTH));
	assign rd_tok = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`BSD_ASSERT(a_no_overflow, !(push && stat.full))
	`BSD_ASSERT(a_no_underflow, !(pop && stat.empty))
	`BSD_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
endmodule

[src/bsd_back.sv]
// Back end: holds one byte back to mark frame ends, output queue.
`include "byte_stuffing_deframer_defines.svh"
module bsd_back (
	input  logic clk,
	input  logic arst_n,
	input  bsd_pkg::token_t tok,
	input  bsd_pkg::qstat_t tq_stat,
	output logic tok_pop,
	input  logic pop,
	output logic empty,
	output logic [bsd_pkg::BYTE_W-1:0] msg_byte,
	output logic msg_last
);
	import bsd_pkg::*;

	logic [BYTE_W-1:0] held_byte_q;
	logic held_valid_q;
	logic [BYTE_W-1:0] obyte_q [2];
	logic olast_q [2];
	logic owr_q;
	logic ord_q;
	logic [1:0] ocnt_q;
	logic room;
	logic emit;
	logic opop;

	assign room = (ocnt_q != 2'd2);
	assign tok_pop = !tq_stat.empty && room;
	assign emit = tok_pop && held_valid_q;
	assign empty = (ocnt_q == 2'd0);
	assign opop = pop && !empty;
	assign msg_byte = obyte_q[ord_q];
	assign msg_last = olast_q[ord_q];

	always_ff @(posedge clk) begin
		if (emit) begin
			obyte_q[owr_q] <= held_byte_q;
			olast_q[owr_q] <= tok.is_end;
		end
		if (tok_pop && !tok.is_end) begin
			held_byte_q <= tok.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			owr_q <= 1'b0;
			ord_q <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (tok_pop) begin
				held_valid_q <= !tok.is_end;
			end
			if (emit) begin
				owr_q <= !owr_q;
			end
			if (opop) begin
				ord_q <= !ord_q;
			end
			if (emit && !opop) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (opop && !emit) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

	`BSD_ASSERT(a_ocnt_range, ocnt_q != 2'd3)
	`BSD_ASSERT(a_emit_has_room, !(emit && !room))
	`BSD_ASSERT_NEXT(a_end_clears, tok_pop && tok.is_end, !held_valid_q)
endmodule

[src/byte_stuffing_deframer.sv]
// Top level of the byte stuffing deframer.
//
// Input channel: push/full. A raw link byte on rx_byte is taken at a clock
// edge with push high and full low. One byte per cycle while full stays low.
// Result channel: empty/pop. While empty is low, msg_byte/msg_last show the
// oldest decoded byte; it is taken at an edge with pop high.
// Escape + end byte closes a frame and marks the frame's final byte with
// msg_last; escape + any other byte gives that byte as data. Empty frames
// give nothing. Each decoded byte is held back until the next data byte or
// frame end arrives; once the releasing item has passed the token queue, the
// back end writes the byte to the output queue, from which it can be popped.
// Throughput without stalls: one item per cycle in both front and back end.
// A 4-entry token queue sits between them and a 2-entry output queue at the
// result side; when the receiver stalls both fill and full rises.
// Config: cfg_valid/cfg_ready write escape_byte (index 0) or end_byte
// (index 1); cfg_ready is always high. Write only while idle.
// Reset clears escape state, held byte and queues; escape_byte=0, end_byte=1.
module byte_stuffing_deframer (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [bsd_pkg::BYTE_W-1:0] rx_byte,
	output logic empty,
	input  logic pop,
	output logic [bsd_pkg::BYTE_W-1:0] msg_byte,
	output logic msg_last,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [bsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsd_pkg::BYTE_W-1:0] cfg_data
);
	import bsd_pkg::*;

	logic [BYTE_W-1:0] escape_byte_q;
	logic [BYTE_W-1:0] end_byte_q;
	qstat_t tq_stat;
	token_t wr_tok;
	token_t rd_tok;
	logic tok_push;
	logic tok_pop;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_byte_q <= ESCAPE_RST;
			end_byte_q <= END_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ESCAPE: escape_byte_q <= cfg_data;
				REG_END: end_byte_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bsd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.rx_byte(rx_byte),
		.escape_byte(escape_byte_q),
		.end_byte(end_byte_q),
		.tq_stat(tq_stat),
		.full(full),
		.tok_push(tok_push),
		.tok(wr_tok)
	);

	bsd_tokq u_tokq (
		.clk(clk),
		.arst_n(arst_n),
		.push(tok_push),
		.wr_tok(wr_tok),
		.pop(tok_pop),
		.rd_tok(rd_tok),
		.stat(tq_stat)
	);

	bsd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.tok(rd_tok),
		.tq_stat(tq_stat),
		.tok_pop(tok_pop),
		.pop(pop),
		.empty(empty),
		.msg_byte(msg_byte),
		.msg_last(msg_last)
	);
endmodule
